/* src/rmc_pkg.sv */
// ----------------------------------------------------------------------------
// rmc_pkg
// Shared types and codes for the rotate / mirror / crop coordinate mapper.
// ----------------------------------------------------------------------------
package rmc_pkg;

  // Request payload: one output grid coordinate
  typedef struct packed {
    logic [11:0] dest_x;
    logic [11:0] dest_y;
  } in_t;

  // Result payload
  typedef struct packed {
    logic [11:0] src_x;
    logic [11:0] src_y;
    logic [12:0] result_width;
    logic [12:0] result_height;
    logic [2:0]  status;
  } out_t;

  // Configuration register set
  typedef struct packed {
    logic [4:0]  transform_mode;
    logic [12:0] source_width;
    logic [12:0] source_height;
    logic [11:0] crop_left;
    logic [11:0] crop_top;
    logic [12:0] crop_width;
    logic [12:0] crop_height;
  } cfg_t;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO_SRC  = 3'd1;
  localparam logic [2:0] ST_ZERO_CROP = 3'd2;
  localparam logic [2:0] ST_CROP_OOB  = 3'd3;
  localparam logic [2:0] ST_COORD_OOR = 3'd4;

  // Register indexes
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_SRC_W    = 3'd1;
  localparam logic [2:0] REG_SRC_H    = 3'd2;
  localparam logic [2:0] REG_CROP_L   = 3'd3;
  localparam logic [2:0] REG_CROP_T   = 3'd4;
  localparam logic [2:0] REG_CROP_W   = 3'd5;
  localparam logic [2:0] REG_CROP_H   = 3'd6;

  // Quarter-turn codes in transform_mode[1:0]
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // Mode bit positions
  localparam int MODE_MIR_X = 2;
  localparam int MODE_MIR_Y = 3;
  localparam int MODE_CROP  = 4;

endpackage

/* src/rmc_pipe.sv */
// ----------------------------------------------------------------------------
// rmc_pipe
// Three-stage coordinate mapping pipeline: config check and crop offset,
// range check and mirror, rotation and output register.
// ----------------------------------------------------------------------------
module rmc_pipe #(
  parameter int MAX_DIM = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  rmc_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_stall,
  input  rmc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rmc_pkg::out_t out_data
);
  import rmc_pkg::*;

  localparam logic [16:0] MaxDimW = 17'(MAX_DIM);

  typedef struct packed {
    logic [11:0] dx;
    logic [11:0] dy;
    logic [12:0] xr;
    logic [12:0] yr;
    logic [12:0] out_w;
    logic [12:0] out_h;
    logic [2:0]  status;
  } s1_t;

  typedef struct packed {
    logic [12:0] xm;
    logic [12:0] ym;
    logic [12:0] out_w;
    logic [12:0] out_h;
    logic [2:0]  status;
  } s2_t;

  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  out_t s3_r, s3_nxt;
  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  // Config decode shared by all stages (static while requests are in flight)
  logic        swap, crop, mir_x, mir_y;
  logic [12:0] w_rot, h_rot;
  assign swap  = cfg.transform_mode[0];
  assign mir_x = cfg.transform_mode[MODE_MIR_X];
  assign mir_y = cfg.transform_mode[MODE_MIR_Y];
  assign crop  = cfg.transform_mode[MODE_CROP];
  assign w_rot = swap ? cfg.source_height : cfg.source_width;
  assign h_rot = swap ? cfg.source_width  : cfg.source_height;

  // Stage enables: a stage moves when it is empty or the next one moves
  assign en3      = !v3_r || !out_stall;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  // Stage 1: config checks, output size, crop offset
  logic src_bad, crop_zero, crop_oob;
  always_comb begin
    src_bad   = (cfg.source_width == '0) || (cfg.source_height == '0) ||
                ({4'b0, cfg.source_width} > MaxDimW) ||
                ({4'b0, cfg.source_height} > MaxDimW);
    crop_zero = (cfg.crop_width == '0) || (cfg.crop_height == '0);
    crop_oob  = (14'(cfg.crop_left) + 14'(cfg.crop_width) > 14'(w_rot)) ||
                (14'(cfg.crop_top) + 14'(cfg.crop_height) > 14'(h_rot));

    s1_nxt.dx = in_data.dest_x;
    s1_nxt.dy = in_data.dest_y;
    if (crop) begin
      s1_nxt.xr    = 13'(in_data.dest_x) + 13'(cfg.crop_left);
      s1_nxt.yr    = 13'(in_data.dest_y) + 13'(cfg.crop_top);
      s1_nxt.out_w = cfg.crop_width;
      s1_nxt.out_h = cfg.crop_height;
    end else begin
      s1_nxt.xr    = 13'(in_data.dest_x);
      s1_nxt.yr    = 13'(in_data.dest_y);
      s1_nxt.out_w = w_rot;
      s1_nxt.out_h = h_rot;
    end

    priority if (src_bad) begin
      s1_nxt.status = ST_ZERO_SRC;
    end else if (crop && crop_zero) begin
      s1_nxt.status = ST_ZERO_CROP;
    end else if (crop && crop_oob) begin
      s1_nxt.status = ST_CROP_OOB;
    end else begin
      s1_nxt.status = ST_OK;
    end
  end

  // Stage 2: coordinate range check, mirrors in rotated space
  logic coord_oor;
  always_comb begin
    coord_oor = ({1'b0, s1_r.dx} >= s1_r.out_w) || ({1'b0, s1_r.dy} >= s1_r.out_h);
    s2_nxt.out_w = s1_r.out_w;
    s2_nxt.out_h = s1_r.out_h;
    s2_nxt.xm    = mir_x ? (w_rot - 13'd1 - s1_r.xr) : s1_r.xr;
    s2_nxt.ym    = mir_y ? (h_rot - 13'd1 - s1_r.yr) : s1_r.yr;
    if (s1_r.status != ST_OK) begin
      s2_nxt.status = s1_r.status;
    end else if (coord_oor) begin
      s2_nxt.status = ST_COORD_OOR;
    end else begin
      s2_nxt.status = ST_OK;
    end
  end

  // Stage 3: undo the rotation, zero source on error, size on config error
  logic [12:0] sx, sy;
  always_comb begin
    unique case (cfg.transform_mode[1:0])
      ROT_0: begin
        sx = s2_r.xm;
        sy = s2_r.ym;
      end
      ROT_90: begin
        sx = s2_r.ym;
        sy = cfg.source_height - 13'd1 - s2_r.xm;
      end
      ROT_180: begin
        sx = cfg.source_width - 13'd1 - s2_r.xm;
        sy = cfg.source_height - 13'd1 - s2_r.ym;
      end
      ROT_270: begin
        sx = cfg.source_width - 13'd1 - s2_r.ym;
        sy = s2_r.xm;
      end
      default: begin
        sx = '0;
        sy = '0;
      end
    endcase

    s3_nxt.status = s2_r.status;
    if (s2_r.status == ST_OK) begin
      s3_nxt.src_x = sx[11:0];
      s3_nxt.src_y = sy[11:0];
    end else begin
      s3_nxt.src_x = '0;
      s3_nxt.src_y = '0;
    end
    if ((s2_r.status == ST_OK) || (s2_r.status == ST_COORD_OOR)) begin
      s3_nxt.result_width  = s2_r.out_w;
      s3_nxt.result_height = s2_r.out_h;
    end else begin
      s3_nxt.result_width  = '0;
      s3_nxt.result_height = '0;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en1) s1_r <= s1_nxt;
    if (en2) s2_r <= s2_nxt;
    if (en3) s3_r <= s3_nxt;
  end

  assign out_valid = v3_r;
  assign out_data  = s3_r;

endmodule

/* src/rotate_mirror_crop_coord_map.sv */
// ----------------------------------------------------------------------------
// rotate_mirror_crop_coord_map
// Maps an output grid coordinate back to its source cell under a
// quarter-turn rotation, optional mirrors and an optional crop.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel takes one request (dest_x, dest_y) per cycle when
//   in_valid is high and in_stall is low. Each request gives exactly one
//   result on the out_ channel: source coordinate, transformed grid size and
//   a status code, taken when out_valid is high and out_stall is low.
//   Throughput is one request per cycle while out_stall stays low, set by
//   the three register stages (config check and crop offset, range check
//   and mirror, rotation and output register).
//   When the receiver stalls, stages fill up behind the output register and
//   in_stall rises only once every stage holds a request; nothing is lost.
//   The APB-style cfg_ port holds seven registers at byte addresses 4*i;
//   write them only while no request is in flight. Synchronous reset drops
//   all requests in flight and loads the register reset values (mode 0,
//   sizes 1, crop origin 0). There is no clearing pass.
// ----------------------------------------------------------------------------
module rotate_mirror_crop_coord_map #(
  parameter int MAX_DIM = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rmc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rmc_pkg::out_t out_data,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [4:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);
  import rmc_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:   cfg_nxt.transform_mode = cfg_pwdata[4:0];
        REG_SRC_W:  cfg_nxt.source_width   = cfg_pwdata[12:0];
        REG_SRC_H:  cfg_nxt.source_height  = cfg_pwdata[12:0];
        REG_CROP_L: cfg_nxt.crop_left      = cfg_pwdata[11:0];
        REG_CROP_T: cfg_nxt.crop_top       = cfg_pwdata[11:0];
        REG_CROP_W: cfg_nxt.crop_width     = cfg_pwdata[12:0];
        REG_CROP_H: cfg_nxt.crop_height    = cfg_pwdata[12:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.transform_mode <= '0;
      cfg_r.source_width   <= 13'd1;
      cfg_r.source_height  <= 13'd1;
      cfg_r.crop_left      <= '0;
      cfg_r.crop_top       <= '0;
      cfg_r.crop_width     <= 13'd1;
      cfg_r.crop_height    <= 13'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Register read mux
  always_comb begin
    unique case (reg_idx)
      REG_MODE:   cfg_prdata = 32'(cfg_r.transform_mode);
      REG_SRC_W:  cfg_prdata = 32'(cfg_r.source_width);
      REG_SRC_H:  cfg_prdata = 32'(cfg_r.source_height);
      REG_CROP_L: cfg_prdata = 32'(cfg_r.crop_left);
      REG_CROP_T: cfg_prdata = 32'(cfg_r.crop_top);
      REG_CROP_W: cfg_prdata = 32'(cfg_r.crop_width);
      REG_CROP_H: cfg_prdata = 32'(cfg_r.crop_height);
      default:    cfg_prdata = '0;
    endcase
  end

  rmc_pipe #(
    .MAX_DIM (MAX_DIM)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* src/rmc_chk.sv */
// ----------------------------------------------------------------------------
// rmc_chk
// Port-level checks for the coordinate mapper, bound to the top level.
// ----------------------------------------------------------------------------
module rmc_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input rmc_pkg::out_t out_data
);
  import rmc_pkg::*;

  // A bad configuration reports a zero grid size
  a_cfg_err_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_ZERO_SRC || out_data.status == ST_ZERO_CROP ||
                  out_data.status == ST_CROP_OOB)
    |-> out_data.result_width == '0 && out_data.result_height == '0)
    else $error("config error with nonzero result size");

  // Out-of-range coordinate: zero source, valid nonzero grid size
  a_oor_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_COORD_OOR
    |-> out_data.src_x == '0 && out_data.src_y == '0 &&
        out_data.result_width != '0 && out_data.result_height != '0)
    else $error("out-of-range result fields wrong");

  // A good mapping lies inside a nonempty grid
  a_ok_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_OK
    |-> out_data.result_width != '0 && out_data.result_height != '0)
    else $error("ok result with empty grid");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Input stalls only behind a held result
  a_in_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

endmodule

bind rotate_mirror_crop_coord_map rmc_chk u_chk (.*);

/* tb/tb_rotate_mirror_crop_coord_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coordinate mapper testbench
// Directed and random requests through the rotate / mirror / crop mapper.
// Each request is predicted from a shadow copy of the registers and every
// result is checked in order against it, under three stall patterns.
// ----------------------------------------------------------------------------
module tb_rotate_mirror_crop_coord_map;
  import rmc_pkg::*;

  // Shadow registers, source-coordinate predictor and queue of pending results
  class coord_ledger;
    localparam int MAX_DIM = 4096;

    cfg_t settings;
    out_t pending_results[$];
    int   mismatches;
    int   compared;

    function new();
      settings = cfg_t'{5'd0, 13'd1, 13'd1, 12'd0, 12'd0, 13'd1, 13'd1};
      mismatches = 0;
      compared = 0;
    endfunction

    // Register write; unused indexes are ignored
    function void write_setting(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_MODE:   settings.transform_mode = value[4:0];
        REG_SRC_W:  settings.source_width   = value[12:0];
        REG_SRC_H:  settings.source_height  = value[12:0];
        REG_CROP_L: settings.crop_left      = value[11:0];
        REG_CROP_T: settings.crop_top       = value[11:0];
        REG_CROP_W: settings.crop_width     = value[12:0];
        REG_CROP_H: settings.crop_height    = value[12:0];
        default: ;
      endcase
    endfunction

    // Map an output coordinate back to its source cell
    function out_t map_to_source(in_t req);
      out_t r;
      int   sw, sh, wr, hr, ow, oh, xr, yr, sx, sy;
      int   cl, ct, cw, ch;
      logic [1:0] turns;
      logic mir_x, mir_y, crop_en;
      r = '0;
      sw = settings.source_width;
      sh = settings.source_height;
      cl = settings.crop_left;
      ct = settings.crop_top;
      cw = settings.crop_width;
      ch = settings.crop_height;
      turns   = settings.transform_mode[1:0];
      mir_x   = settings.transform_mode[MODE_MIR_X];
      mir_y   = settings.transform_mode[MODE_MIR_Y];
      crop_en = settings.transform_mode[MODE_CROP];

      // oversized counts as bad source size
      if (sw == 0 || sh == 0 || sw > MAX_DIM || sh > MAX_DIM) begin
        r.status = ST_ZERO_SRC;
        return r;
      end
      wr = turns[0] ? sh : sw;
      hr = turns[0] ? sw : sh;

      if (crop_en) begin
        if (cw == 0 || ch == 0) begin
          r.status = ST_ZERO_CROP;
          return r;
        end
        if (cl + cw > wr || ct + ch > hr) begin
          r.status = ST_CROP_OOB;
          return r;
        end
        ow = cw;
        oh = ch;
      end else begin
        ow = wr;
        oh = hr;
      end
      r.result_width  = ow[12:0];
      r.result_height = oh[12:0];

      if (int'(req.dest_x) >= ow || int'(req.dest_y) >= oh) begin
        r.status = ST_COORD_OOR;
        return r;
      end

      xr = int'(req.dest_x) + (crop_en ? cl : 0);
      yr = int'(req.dest_y) + (crop_en ? ct : 0);
      if (mir_x) xr = wr - 1 - xr;
      if (mir_y) yr = hr - 1 - yr;

      case (turns)
        ROT_0: begin
          sx = xr;
          sy = yr;
        end
        ROT_90: begin
          sx = yr;
          sy = sh - 1 - xr;
        end
        ROT_180: begin
          sx = sw - 1 - xr;
          sy = sh - 1 - yr;
        end
        default: begin
          sx = sw - 1 - yr;
          sy = xr;
        end
      endcase
      r.src_x  = sx[11:0];
      r.src_y  = sy[11:0];
      r.status = ST_OK;
      return r;
    endfunction

    function void note_request(in_t req);
      pending_results.push_back(map_to_source(req));
    endfunction

    function void check_result(out_t got);
      out_t exp;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, nothing pending: src=(%0d,%0d) size=%0dx%0d st=%0d",
                 $time, got.src_x, got.src_y, got.result_width, got.result_height,
                 got.status);
        return;
      end
      exp = pending_results.pop_front();
      compared++;
      if (got.src_x != exp.src_x || got.src_y != exp.src_y ||
          got.result_width != exp.result_width ||
          got.result_height != exp.result_height || got.status != exp.status) begin
        mismatches++;
        $display("%0t: mismatch exp src=(%0d,%0d) size=%0dx%0d st=%0d", $time,
                 exp.src_x, exp.src_y, exp.result_width, exp.result_height, exp.status);
        $display("%0t:          got src=(%0d,%0d) size=%0dx%0d st=%0d", $time,
                 got.src_x, got.src_y, got.result_width, got.result_height, got.status);
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  localparam logic [2:0] REG_UNUSED     = 3'd7;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         HOLDOFF_CYCLES = 60;
  localparam int         DRAIN_CYCLES   = 8;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  in_t         in_data     = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  out_t        out_data;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [4:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  coord_ledger ledger = new();

  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int holdoff_asked   = 0;
  int requests_sent   = 0;
  int settings_loaded = 0;

  rotate_mirror_crop_coord_map dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 250 MHz clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Result side: check accepted results, drive random stall and hold-offs
  initial begin
    int holdoff_granted;
    int holdoff_left;
    holdoff_granted = 0;
    holdoff_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) ledger.check_result(out_data);
      if (holdoff_asked > holdoff_granted) begin
        holdoff_granted++;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: cycles with no request or result moving
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no progress for %0d cycles, %0d results pending", $time,
             WATCHDOG_LIMIT, ledger.pending());
    $display("FAILED: results differ");
    $finish;
  end

  // One register write: setup then access cycle
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    ledger.write_setting(idx, value);
  endtask

  task automatic end_cfg_access();
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Sender pause until every pending result is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t c);
    wait_for_results();
    write_reg(REG_MODE,   32'(c.transform_mode));
    write_reg(REG_SRC_W,  32'(c.source_width));
    write_reg(REG_SRC_H,  32'(c.source_height));
    write_reg(REG_CROP_L, 32'(c.crop_left));
    write_reg(REG_CROP_T, 32'(c.crop_top));
    write_reg(REG_CROP_W, 32'(c.crop_width));
    write_reg(REG_CROP_H, 32'(c.crop_height));
    end_cfg_access();
    settings_loaded++;
  endtask

  // Offer one request after a random gap, hold it until accepted
  task automatic send_request(input in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ledger.note_request(req);
    requests_sent++;
  endtask

  task automatic send_xy(input int x, input int y);
    in_t req;
    req.dest_x = 12'(x);
    req.dest_y = 12'(y);
    send_request(req);
  endtask

  function automatic logic [4:0] mode_of(logic crop, logic mir_y, logic mir_x,
                                         logic [1:0] turns);
    return {crop, mir_y, mir_x, turns};
  endfunction

  // Grid size: mostly small, sometimes zero, full or oversized
  function automatic logic [12:0] pick_dim();
    int roll;
    roll = $urandom_range(99);
    if (roll < 4) return 13'd0;
    if (roll < 8) return 13'd4096;
    if (roll < 11) return 13'($urandom_range(8191, 4097));
    if (roll < 15) return 13'($urandom_range(4095, 17));
    return 13'($urandom_range(16, 1));
  endfunction

  // Random register set; crop mostly inside the rotated grid
  function automatic cfg_t pick_settings();
    cfg_t c;
    int   wr, hr, cw, ch;
    c.transform_mode = 5'($urandom_range(31));
    c.source_width   = pick_dim();
    c.source_height  = pick_dim();
    wr = c.transform_mode[0] ? c.source_height : c.source_width;
    hr = c.transform_mode[0] ? c.source_width : c.source_height;
    if ($urandom_range(99) < 15 || wr == 0 || hr == 0 || wr > 4096 || hr > 4096) begin
      c.crop_left   = ($urandom_range(1) != 0) ? 12'($urandom) : 12'($urandom_range(8));
      c.crop_top    = ($urandom_range(1) != 0) ? 12'($urandom) : 12'($urandom_range(8));
      c.crop_width  = ($urandom_range(3) == 0) ? 13'($urandom) : 13'($urandom_range(12));
      c.crop_height = ($urandom_range(3) == 0) ? 13'($urandom) : 13'($urandom_range(12));
    end else begin
      cw = $urandom_range(wr, 1);
      ch = $urandom_range(hr, 1);
      c.crop_width  = 13'(cw);
      c.crop_height = 13'(ch);
      c.crop_left   = 12'($urandom_range(wr - cw));
      c.crop_top    = 12'($urandom_range(hr - ch));
    end
    return c;
  endfunction

  // Mostly in-range coordinates, some at the edge, some anywhere
  task automatic send_random_request();
    out_t probe;
    int   roll, x, y;
    probe = ledger.map_to_source('0);
    roll = $urandom_range(99);
    if (probe.result_width != 0 && roll < 80) begin
      x = $urandom_range(int'(probe.result_width) - 1);
      y = $urandom_range(int'(probe.result_height) - 1);
    end else if (probe.result_width != 0 && roll < 88) begin
      x = int'(probe.result_width) - $urandom_range(1);
      y = int'(probe.result_height) - $urandom_range(1);
      if (x > 4095) x = 4095;
      if (y > 4095) y = 4095;
    end else begin
      x = $urandom_range(4095);
      y = $urandom_range(4095);
    end
    send_xy(x, y);
  endtask

  // Main sequence
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: 1x1 grid, identity
    send_xy(0, 0);
    send_xy(0, 1);
    send_xy(4095, 4095);

    // zero source size, then oversized source ahead of a zero crop
    load_settings(cfg_t'{mode_of(0, 0, 0, ROT_0), 13'd0, 13'd5,
                         12'd0, 12'd0, 13'd1, 13'd1});
    send_xy(0, 0);
    load_settings(cfg_t'{mode_of(1, 0, 0, ROT_0), 13'd4097, 13'd8191,
                         12'd0, 12'd0, 13'd0, 13'd0});
    send_xy(0, 0);

    // largest grid
    load_settings(cfg_t'{mode_of(0, 0, 0, ROT_0), 13'd4096, 13'd4096,
                         12'd0, 12'd0, 13'd1, 13'd1});
    send_xy(4095, 4095);
    send_xy(0, 4095);

    // crop off: bad crop registers must be ignored
    load_settings(cfg_t'{mode_of(0, 1, 1, ROT_90), 13'd7, 13'd5,
                         12'd4095, 12'd4095, 13'd0, 13'd0});
    send_xy(0, 0);
    send_xy(4, 6);
    send_xy(5, 0);

    // zero crop size; zero size wins over bounds
    load_settings(cfg_t'{mode_of(1, 0, 0, ROT_90), 13'd7, 13'd5,
                         12'd0, 12'd0, 13'd3, 13'd0});
    send_xy(0, 0);
    load_settings(cfg_t'{mode_of(1, 0, 0, ROT_0), 13'd7, 13'd5,
                         12'd4095, 12'd0, 13'd0, 13'd1});
    send_xy(0, 0);

    // crop past the rotated width
    load_settings(cfg_t'{mode_of(1, 0, 0, ROT_90), 13'd7, 13'd5,
                         12'd3, 12'd0, 13'd3, 13'd2});
    send_xy(1, 1);

    // crop flush with the rotated edges
    load_settings(cfg_t'{mode_of(1, 1, 0, ROT_270), 13'd7, 13'd5,
                         12'd2, 12'd0, 13'd3, 13'd7});
    send_xy(0, 0);
    send_xy(2, 6);
    send_xy(3, 0);

    // crop origin at its maximum
    load_settings(cfg_t'{mode_of(1, 0, 1, ROT_180), 13'd4096, 13'd4096,
                         12'd4095, 12'd4095, 13'd1, 13'd1});
    send_xy(0, 0);
    send_xy(0, 1);

    // write to an unused index leaves the setting alone
    wait_for_results();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    end_cfg_access();
    send_xy(0, 0);

    // random part under three stall patterns
    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 58;
        end
        1: begin
          send_idle_pct = 58;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int phase = 0; phase < 10; phase++) begin
        load_settings(pick_settings());
        // long receiver hold-off while requests keep coming
        if (phase == 2 && regime != 1) holdoff_asked++;
        for (int k = 0; k < 25; k++) send_random_request();
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests and %0d checked results over %0d register sets,",
             requests_sent, ledger.compared, settings_loaded);
    $display("with all rotations, mirrors, crop cases and three stall patterns.");
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
